// ===== hdl/mwo_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the mecanum wheel odometry unit
package mwo_pkg;

    // input item: four wheel speeds, signed Q4.12 rad/s
    typedef struct packed {
        logic signed [15:0] front_left_speed;
        logic signed [15:0] front_right_speed;
        logic signed [15:0] rear_left_speed;
        logic signed [15:0] rear_right_speed;
    } mwo_in_t;

    // result item
    typedef struct packed {
        logic signed [15:0] velocity_first_axis;
        logic signed [15:0] velocity_second_axis;
        logic signed [15:0] yaw_rate;
        logic signed [31:0] position_first;
        logic signed [31:0] position_second;
        logic signed [19:0] heading;
        logic        [15:0] speed_magnitude;
    } mwo_out_t;

    // configuration register indexes
    localparam logic [1:0] CFG_LINEAR_GAIN   = 2'd0;
    localparam logic [1:0] CFG_TURN_GAIN     = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_PERIOD = 2'd2;

    // register reset values
    localparam logic [15:0] LINEAR_GAIN_RESET   = 16'd1663;
    localparam logic [15:0] TURN_GAIN_RESET     = 16'd2845;
    localparam logic [23:0] SAMPLE_PERIOD_RESET = 24'd16777;

    // two pi in Q3.16, on the widened internal heading
    localparam logic signed [21:0] HEADING_TWO_PI = 22'sd411775;

    // square root runs one result bit per step, highest step first
    localparam logic [3:0] SQRT_STEP_FIRST = 4'd15;
    localparam logic [3:0] SQRT_STEP_LAST  = 4'd0;

    // operations of the shared multiplier
    typedef enum logic [2:0] {
        OP_VX  = 3'd0,
        OP_VY  = 3'd1,
        OP_WZ  = 3'd2,
        OP_PX  = 3'd3,
        OP_PY  = 3'd4,
        OP_HD  = 3'd5,
        OP_SQX = 3'd6,
        OP_SQY = 3'd7
    } mwo_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       mul;
        logic       acc;
        logic       sqrt_step;
        logic       wrap;
        logic       publish;
        mwo_op_t    op;
        logic [3:0] step;
    } mwo_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } mwo_status_t;

endpackage

// ===== hdl/mwo_dp.sv =====
`timescale 1ns / 1ps
// datapath: config registers, shared multiplier, pose state, square root, output register
module mwo_dp
    import mwo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    input  mwo_in_t      in_data,
    input  mwo_cmd_t     cmd,
    output mwo_status_t  status,
    output logic         out_valid,
    input  logic         out_ready,
    output mwo_out_t     out_data
);

    // divide by a power of two, rounding half away from zero
    function automatic logic signed [42:0] shr_round(input logic signed [42:0] v,
                                                     input logic [4:0] sh);
        logic        neg;
        logic [42:0] mag;
        logic [42:0] r;
        neg = v[42];
        mag = neg ? 43'(-v) : 43'(v);
        r   = (mag + (43'd1 << (sh - 5'd1))) >> sh;
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [42:0] v);
        logic signed [15:0] s;
        if (v > 43'sd32767)
            s = 16'sh7fff;
        else if (v < -43'sd32768)
            s = 16'sh8000;
        else
            s = 16'(v);
        return s;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [31:0] s;
        if (v > 43'sd2147483647)
            s = 32'sh7fffffff;
        else if (v < -43'sd2147483648)
            s = 32'sh80000000;
        else
            s = 32'(v);
        return s;
    endfunction

    logic [15:0] linear_gain_reg;
    logic [15:0] turn_gain_reg;
    logic [23:0] sample_period_reg;

    logic signed [17:0] sum_first_reg;
    logic signed [17:0] sum_second_reg;
    logic signed [17:0] sum_turn_reg;

    logic signed [15:0] v_first_reg;
    logic signed [15:0] v_second_reg;
    logic signed [15:0] wz_reg;
    logic signed [15:0] last_first_reg;
    logic signed [15:0] last_second_reg;

    logic signed [31:0] pose_first_reg;
    logic signed [31:0] pose_second_reg;
    logic signed [21:0] heading_reg;
    logic signed [21:0] heading_next;

    logic signed [42:0] prod_reg;
    logic signed [42:0] prod_next;
    logic signed [17:0] mul_a;
    logic signed [24:0] mul_b;

    logic [31:0] rem_reg;
    logic [31:0] res_reg;
    logic [31:0] sqrt_bit;
    logic [31:0] sqrt_trial;

    logic [4:0]         rnd_shift;
    logic signed [42:0] rnd;
    logic signed [42:0] pose_first_sum;
    logic signed [42:0] pose_second_sum;

    logic     out_valid_reg;
    mwo_out_t out_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_gain_reg   <= LINEAR_GAIN_RESET;
            turn_gain_reg     <= TURN_GAIN_RESET;
            sample_period_reg <= SAMPLE_PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LINEAR_GAIN:   linear_gain_reg   <= cfg_data[15:0];
                CFG_TURN_GAIN:     turn_gain_reg     <= cfg_data[15:0];
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // wheel sign patterns, formed once per item
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sum_first_reg  <= 18'(in_data.front_left_speed) - 18'(in_data.front_right_speed)
                            - 18'(in_data.rear_left_speed) + 18'(in_data.rear_right_speed);
            sum_second_reg <= 18'(in_data.front_left_speed) + 18'(in_data.front_right_speed)
                            + 18'(in_data.rear_left_speed) + 18'(in_data.rear_right_speed);
            sum_turn_reg   <= 18'(in_data.front_right_speed) - 18'(in_data.front_left_speed)
                            - 18'(in_data.rear_left_speed) + 18'(in_data.rear_right_speed);
        end
    end

    // multiplier operand select
    always_comb
    begin
        unique case (cmd.op)
            OP_VX:
            begin
                mul_a = sum_first_reg;
                mul_b = $signed({9'd0, linear_gain_reg});
            end
            OP_VY:
            begin
                mul_a = sum_second_reg;
                mul_b = $signed({9'd0, linear_gain_reg});
            end
            OP_WZ:
            begin
                mul_a = sum_turn_reg;
                mul_b = $signed({9'd0, turn_gain_reg});
            end
            OP_PX:
            begin
                mul_a = 18'(last_first_reg) + 18'(v_first_reg);
                mul_b = $signed({1'b0, sample_period_reg});
            end
            OP_PY:
            begin
                mul_a = 18'(last_second_reg) + 18'(v_second_reg);
                mul_b = $signed({1'b0, sample_period_reg});
            end
            OP_HD:
            begin
                mul_a = 18'(wz_reg);
                mul_b = $signed({1'b0, sample_period_reg});
            end
            OP_SQX:
            begin
                mul_a = 18'(v_first_reg);
                mul_b = 25'(v_first_reg);
            end
            OP_SQY:
            begin
                mul_a = 18'(v_second_reg);
                mul_b = 25'(v_second_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared multiplier, registered
    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prod_reg <= prod_next;
    end

    // rounding shift per operation
    always_comb
    begin
        case (cmd.op) inside
            OP_PX, OP_PY: rnd_shift = 5'd21;
            OP_HD:        rnd_shift = 5'd20;
            default:      rnd_shift = 5'd16;
        endcase
    end

    assign rnd             = shr_round(prod_reg, rnd_shift);
    assign pose_first_sum  = 43'(pose_first_reg) + rnd;
    assign pose_second_sum = 43'(pose_second_reg) + rnd;

    // square root step values
    assign sqrt_bit   = 32'd1 << {cmd.step, 1'b0};
    assign sqrt_trial = res_reg + sqrt_bit;

    // one wrap step by two pi
    always_comb
    begin
        if (heading_reg >= HEADING_TWO_PI)
            heading_next = heading_reg - HEADING_TWO_PI;
        else if (heading_reg < -HEADING_TWO_PI)
            heading_next = heading_reg + HEADING_TWO_PI;
        else
            heading_next = heading_reg;
    end

    // velocities and square root working registers
    always_ff @(posedge clk)
    begin
        if (cmd.acc)
        begin
            case (cmd.op)
                OP_VX:  v_first_reg  <= sat16(rnd);
                OP_VY:  v_second_reg <= sat16(rnd);
                OP_WZ:  wz_reg       <= sat16(rnd);
                OP_SQX: rem_reg      <= prod_reg[31:0];
                OP_SQY:
                begin
                    rem_reg <= rem_reg + prod_reg[31:0];
                    res_reg <= '0;
                end
                default: ;
            endcase
        end
        else if (cmd.sqrt_step)
        begin
            if (rem_reg >= sqrt_trial)
            begin
                rem_reg <= rem_reg - sqrt_trial;
                res_reg <= (res_reg >> 1) + sqrt_bit;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
    end

    // pose and previous velocity state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_first_reg  <= '0;
            pose_second_reg <= '0;
            heading_reg     <= '0;
            last_first_reg  <= '0;
            last_second_reg <= '0;
        end
        else
        begin
            if (cmd.acc)
            begin
                case (cmd.op)
                    OP_PX:   pose_first_reg  <= sat32(pose_first_sum);
                    OP_PY:   pose_second_reg <= sat32(pose_second_sum);
                    OP_HD:   heading_reg     <= heading_reg + 22'(rnd);
                    default: ;
                endcase
            end
            else if (cmd.wrap)
            begin
                heading_reg <= heading_next;
            end
            if (cmd.publish)
            begin
                last_first_reg  <= v_first_reg;
                last_second_reg <= v_second_reg;
            end
        end
    end

    // output item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_reg.velocity_first_axis  <= v_first_reg;
            out_reg.velocity_second_axis <= v_second_reg;
            out_reg.yaw_rate             <= wz_reg;
            out_reg.position_first       <= pose_first_reg;
            out_reg.position_second      <= pose_second_reg;
            out_reg.heading              <= heading_reg[19:0];
            out_reg.speed_magnitude      <= res_reg[15:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    // a publish always leaves a valid item
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid_reg)
        else $error("result not registered after publish");

    // never overwrite an item that was not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("pending item overwritten");

    // heading is wrapped back into range before it is published
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (heading_reg >= -HEADING_TWO_PI && heading_reg < HEADING_TWO_PI))
        else $error("heading out of range at publish");

endmodule

// ===== hdl/mwo_ctrl.sv =====
`timescale 1ns / 1ps
// controller: sequences the multiplier operations, square root steps and publish
module mwo_ctrl
    import mwo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mwo_status_t status,
    output mwo_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MULT = 5'b00010,
        ST_ACC  = 5'b00100,
        ST_SQRT = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    mwo_op_t    op_reg;
    mwo_op_t    op_next;
    logic [3:0] step_reg;
    logic [3:0] step_next;

    // next operation in the fixed order
    function automatic mwo_op_t next_op(input mwo_op_t op);
        mwo_op_t n;
        unique case (op)
            OP_VX:   n = OP_VY;
            OP_VY:   n = OP_WZ;
            OP_WZ:   n = OP_PX;
            OP_PX:   n = OP_PY;
            OP_PY:   n = OP_HD;
            OP_HD:   n = OP_SQX;
            OP_SQX:  n = OP_SQY;
            default: n = OP_VX;
        endcase
        return n;
    endfunction

    // state transitions and commands
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        step_next     = step_reg;
        cmd           = '0;
        cmd.op        = op_reg;
        cmd.step      = step_reg;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    op_next     = OP_VX;
                    state_next  = ST_MULT;
                end
            end
            ST_MULT:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (op_reg == OP_SQY)
                begin
                    step_next  = SQRT_STEP_FIRST;
                    state_next = ST_SQRT;
                end
                else
                begin
                    op_next    = next_op(op_reg);
                    state_next = ST_MULT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cmd.wrap      = 1'b1;
                if (step_reg == SQRT_STEP_LAST)
                    state_next = ST_FIN;
                else
                    step_next = step_reg - 4'd1;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_VX;
            step_reg  <= SQRT_STEP_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            step_reg  <= step_next;
        end
    end

    // an accepted item starts with the first velocity product
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MULT && op_reg == OP_VX))
        else $error("item accepted without starting the sequence");

    // the last product hands over to the full square root run
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC && op_reg == OP_SQY)
            |=> (state_reg == ST_SQRT && step_reg == SQRT_STEP_FIRST))
        else $error("square root not started from its first step");

    // publish returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> state_reg == ST_IDLE)
        else $error("no return to idle after publish");

endmodule

// ===== hdl/mecanum_wheel_odometry_unit.sv =====
`timescale 1ns / 1ps
// top level of the mecanum wheel odometry unit
//
// Takes one item of four wheel speeds and returns one item with body velocities,
// yaw rate, trapezoid-integrated position, wrapped heading and speed. An item
// is accepted, then eight products share one 18x25 multiplier, each with an
// operand select and multiply step followed by a round, saturate and
// accumulate step; the speed square root then produces one result bit per
// step, and the result is published to the output register. A new item is
// accepted in the cycle after publish, while the finished result waits in the
// output register; it only waits further when that register is still held by
// an untaken result. Configuration writes are taken in any cycle and reset
// restores the default gains and period and clears the pose.
module mecanum_wheel_odometry_unit
    import mwo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  mwo_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output mwo_out_t    out_data
);

    mwo_cmd_t    cmd;
    mwo_status_t status;

    // configuration always accepted
    assign cfg_ready = 1'b1;

    mwo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mwo_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== bench/odometry_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard class that predicts and checks odometry result items
package odometry_scoreboard_pkg;

    import mwo_pkg::*;

    class odometry_scoreboard;

        localparam longint VEL_MIN  = -(longint'(1) << 15);
        localparam longint VEL_MAX  = (longint'(1) << 15) - 1;
        localparam longint POSE_MIN = -(longint'(1) << 31);
        localparam longint POSE_MAX = (longint'(1) << 31) - 1;
        localparam int     REPORT_LIMIT = 10;

        // register copies
        logic [15:0] linear_gain;
        logic [15:0] turn_gain;
        logic [23:0] sample_period;

        // integrator state
        longint pose_first;
        longint pose_second;
        longint pose_heading;
        longint prev_vel_first;
        longint prev_vel_second;

        mwo_out_t pending_poses[$];
        int       mismatches;
        int       results_seen;

        function new();
            linear_gain     = LINEAR_GAIN_RESET;
            turn_gain       = TURN_GAIN_RESET;
            sample_period   = SAMPLE_PERIOD_RESET;
            pose_first      = 0;
            pose_second     = 0;
            pose_heading    = 0;
            prev_vel_first  = 0;
            prev_vel_second = 0;
            mismatches      = 0;
            results_seen    = 0;
        endfunction

        // divide by 2^sh, halves rounded away from zero
        static function longint round_shift(longint v, int sh);
            longint mag;
            longint r;
            mag = (v < 0) ? -v : v;
            r = (mag + (longint'(1) << (sh - 1))) >>> sh;
            return (v < 0) ? -r : r;
        endfunction

        static function longint clamp(longint v, longint lo, longint hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        // floor of the square root, one result bit at a time
        static function longint floor_sqrt(longint v);
            longint root;
            longint trial;
            root = 0;
            for (int b = 16; b >= 0; b--)
            begin
                trial = root | (longint'(1) << b);
                if (trial * trial <= v)
                    root = trial;
            end
            return root;
        endfunction

        function void write_reg(logic [1:0] index, logic [23:0] data);
            case (index)
                CFG_LINEAR_GAIN:   linear_gain   = data[15:0];
                CFG_TURN_GAIN:     turn_gain     = data[15:0];
                CFG_SAMPLE_PERIOD: sample_period = data;
                default: ;
            endcase
        endfunction

        // accepted input item: advance the pose and queue the expected result
        function void note_sample(mwo_in_t s);
            longint   fl, fr, rl, rr;
            longint   lg, tg, ts;
            longint   vx, vy, wz, hd;
            mwo_out_t e;
            fl = s.front_left_speed;
            fr = s.front_right_speed;
            rl = s.rear_left_speed;
            rr = s.rear_right_speed;
            lg = linear_gain;
            tg = turn_gain;
            ts = sample_period;

            // body velocities and yaw rate
            vx = clamp(round_shift((fl - fr - rl + rr) * lg, 16), VEL_MIN, VEL_MAX);
            vy = clamp(round_shift((fl + fr + rl + rr) * lg, 16), VEL_MIN, VEL_MAX);
            wz = clamp(round_shift((fr - fl - rl + rr) * tg, 16), VEL_MIN, VEL_MAX);

            // trapezoid integration, halving folded into the shift
            pose_first = clamp(pose_first + round_shift((prev_vel_first + vx) * ts, 21),
                               POSE_MIN, POSE_MAX);
            pose_second = clamp(pose_second + round_shift((prev_vel_second + vy) * ts, 21),
                                POSE_MIN, POSE_MAX);

            // heading wrapped into [-2pi, 2pi)
            hd = pose_heading + round_shift(wz * ts, 20);
            while (hd >= longint'(HEADING_TWO_PI))
                hd -= longint'(HEADING_TWO_PI);
            while (hd < -longint'(HEADING_TWO_PI))
                hd += longint'(HEADING_TWO_PI);
            pose_heading = hd;

            prev_vel_first  = vx;
            prev_vel_second = vy;

            e.velocity_first_axis  = 16'(vx);
            e.velocity_second_axis = 16'(vy);
            e.yaw_rate             = 16'(wz);
            e.position_first       = 32'(pose_first);
            e.position_second      = 32'(pose_second);
            e.heading              = 20'(pose_heading);
            e.speed_magnitude      = 16'(floor_sqrt(vx * vx + vy * vy));
            pending_poses.push_back(e);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (seen !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch in %s at result %0d: expected %0d, got %0d",
                             name, results_seen, $signed(want), $signed(seen));
            end
        endfunction

        // accepted result item against the oldest expectation
        function void check_result(mwo_out_t got);
            mwo_out_t e;
            results_seen++;
            if (pending_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d arrived with nothing expected: %p", results_seen, got);
                return;
            end
            e = pending_poses.pop_front();
            compare_field("velocity_first_axis", 32'(e.velocity_first_axis),
                          32'(got.velocity_first_axis));
            compare_field("velocity_second_axis", 32'(e.velocity_second_axis),
                          32'(got.velocity_second_axis));
            compare_field("yaw_rate", 32'(e.yaw_rate), 32'(got.yaw_rate));
            compare_field("position_first", e.position_first, got.position_first);
            compare_field("position_second", e.position_second, got.position_second);
            compare_field("heading", 32'(e.heading), 32'(got.heading));
            compare_field("speed_magnitude", 32'(e.speed_magnitude),
                          32'(got.speed_magnitude));
        endfunction

        function int outstanding();
            return pending_poses.size();
        endfunction

    endclass

endpackage

// ===== bench/tb_mecanum_wheel_odometry_unit.sv =====
`timescale 1ns / 1ps
// testbench top of the mecanum wheel odometry unit
module tb_mecanum_wheel_odometry_unit;

    import mwo_pkg::*;
    import odometry_scoreboard_pkg::*;

    localparam int         CYCLE_LIMIT     = 3_000_000;
    localparam int         SETTLE_CYCLES   = 40;
    localparam int         DIRECTED_COUNT  = 12;
    localparam int         PRESSURE_CYCLES = 500;
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_LINEAR_GAIN;
    logic [23:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    mwo_in_t     in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    mwo_out_t    out_data;

    odometry_scoreboard board;
    int  samples_sent     = 0;
    int  settings_applied = 0;
    int  quiet_left       = 0;
    int  cycles           = 0;
    bit  long_hold_done   = 1'b0;

    mecanum_wheel_odometry_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data);
    end

    function automatic mwo_in_t wheels(int fl, int fr, int rl, int rr);
        return {16'(fl), 16'(fr), 16'(rl), 16'(rr)};
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 32767;
            1:       return -32768;
            2:       return 0;
            3:       return 1;
            default: return -1;
        endcase
    endfunction

    // extremes and the pure motion patterns
    function automatic mwo_in_t directed_sample(int k);
        case (k)
            0:       return wheels(0, 0, 0, 0);
            1:       return wheels(32767, 32767, 32767, 32767);
            2:       return wheels(-32768, -32768, -32768, -32768);
            3:       return wheels(32767, -32768, -32768, 32767);
            4:       return wheels(-32768, 32767, -32768, 32767);
            5:       return wheels(32767, -32768, 32767, -32768);
            6:       return wheels(1, 1, 1, 1);
            7:       return wheels(-1, -1, -1, -1);
            8:       return wheels('h5555, 'hAAAA, 'h5555, 'hAAAA);
            9:       return wheels(0, -32768, -32768, 0);
            10:      return wheels(32767, 0, 0, 0);
            default: return wheels(0, 0, 0, -32768);
        endcase
    endfunction

    function automatic mwo_in_t random_sample();
        int v;
        int n;
        v = int'($urandom_range(0, 32767));
        n = int'($urandom_range(0, 200)) - 100;
        case ($urandom_range(0, 9)) inside
            0, 1, 2, 3:
                return wheels($urandom, $urandom, $urandom, $urandom);
            4, 5:
                return wheels(int'($urandom_range(0, 4000)) - 2000,
                              int'($urandom_range(0, 4000)) - 2000,
                              int'($urandom_range(0, 4000)) - 2000,
                              int'($urandom_range(0, 4000)) - 2000);
            6:
                return wheels(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
            7:
            begin
                // forward, strafe, turn or diagonal with a little noise
                if ($urandom_range(0, 1) == 1)
                    v = -v;
                case ($urandom_range(0, 3))
                    0:       return wheels(v, v + n, v, v - n);
                    1:       return wheels(v, -v + n, -v, v - n);
                    2:       return wheels(-v, v + n, -v, v - n);
                    default: return wheels(v, n, n, v);
                endcase
            end
            8:
                return wheels(v, v, v, v);
            default:
                return wheels($urandom, $urandom, $urandom, $urandom);
        endcase
    endfunction

    // first axis pinned high, second pinned low: both poses run steadily one way
    function automatic mwo_in_t drift_sample();
        return wheels(int'($urandom_range(0, 1000)), -32768, -32768,
                      int'($urandom_range(0, 1000)));
    endfunction

    // idle cycles before the next item: mostly none or short, a few long
    function automatic int sender_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 2)
        begin
            quiet_left = int'($urandom_range(40, 120));
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 60));
    endfunction

    // called on a clock edge; returns on the edge the item is taken
    task automatic send_sample(mwo_in_t s);
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_sample(s);
        samples_sent++;
    endtask

    task automatic send_with_gap(mwo_in_t s);
        int gap;
        send_sample(s);
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_directed();
        for (int k = 0; k < DIRECTED_COUNT; k++)
            send_with_gap(directed_sample(k));
    endtask

    task automatic run_samples(int count, bit drift);
        for (int k = 0; k < count; k++)
            send_with_gap(drift ? drift_sample() : random_sample());
    endtask

    // stop offering, every result in, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all registers, gains with junk in the unused upper bits
    task automatic apply_settings(logic [15:0] lg, logic [15:0] tg, logic [23:0] ts);
        logic [1:0]  idx [4];
        logic [23:0] val [4];
        idx[0] = CFG_LINEAR_GAIN;
        val[0] = {8'($urandom), lg};
        idx[1] = CFG_TURN_GAIN;
        val[1] = {8'($urandom), tg};
        idx[2] = CFG_SAMPLE_PERIOD;
        val[2] = ts;
        idx[3] = CFG_SPARE_INDEX;
        val[3] = 24'($urandom);
        cfg_valid <= 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            board.write_reg(idx[k], val[k]);
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // receiver: random ready pattern plus one long hold-off to back up the block
    initial
    begin : receiver
        int   r;
        int   dur;
        logic level;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && board.results_seen >= 60)
            begin
                level = 1'b0;
                dur = PRESSURE_CYCLES;
                long_hold_done = 1'b1;
            end
            else
            begin
                r = int'($urandom_range(0, 99));
                if (r < 15)
                begin
                    level = 1'b1;
                    dur = int'($urandom_range(30, 120));
                end
                else if (r < 75)
                begin
                    level = 1'b1;
                    dur = int'($urandom_range(1, 3));
                end
                else if (r < 95)
                begin
                    level = 1'b0;
                    dur = int'($urandom_range(1, 3));
                end
                else
                begin
                    level = 1'b0;
                    dur = int'($urandom_range(10, 60));
                end
            end
            out_ready <= level;
            repeat (dur) @(posedge clk);
        end
    end

    // stimulus
    initial
    begin
        board = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        run_directed();
        run_samples(250, 1'b0);

        // largest gains and period: velocity saturation and heading wrap
        wait_drained();
        apply_settings(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        run_directed();
        run_samples(250, 1'b0);

        // zero gains and period
        wait_drained();
        apply_settings(16'h0000, 16'h0000, 24'h000000);
        run_samples(100, 1'b0);

        // random settings
        for (int p = 0; p < 3; p++)
        begin
            wait_drained();
            apply_settings(16'($urandom), 16'($urandom), 24'($urandom));
            run_samples(250, 1'b0);
        end

        // long one-way drift of both poses, then mixed motion
        wait_drained();
        apply_settings(16'hFFFF, 16'($urandom), 24'hFFFFFF);
        run_samples(500, 1'b1);
        run_samples(100, 1'b0);

        // back to the default setting
        wait_drained();
        apply_settings(LINEAR_GAIN_RESET, TURN_GAIN_RESET, SAMPLE_PERIOD_RESET);
        run_samples(100, 1'b0);

        wait_drained();
        $display("sent %0d wheel samples under %0d register settings, checked %0d results",
                 samples_sent, settings_applied + 1, board.results_seen);
        $display("covered saturated velocities, heading wrap, zero gains and a long pose drift");
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== mecanum_wheel_odometry_unit.f =====
hdl/mwo_pkg.sv
hdl/mwo_dp.sv
hdl/mwo_ctrl.sv
hdl/mecanum_wheel_odometry_unit.sv
bench/odometry_scoreboard_pkg.sv
bench/tb_mecanum_wheel_odometry_unit.sv
